// ===== design/dslf_pkg.sv =====
// Shared types and constants for the display sink lifecycle controller.
// Used by every module of the block; depends on nothing.
package dslf_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [2:0] {
      ST_UNAVAIL       = 3'd0,
      ST_AVAIL         = 3'd1,
      ST_CONNECTING    = 3'd2,
      ST_ACTIVE        = 3'd3,
      ST_DISCONNECTING = 3'd4,
      ST_RECOV         = 3'd5,
      ST_POISONED      = 3'd6,
      ST_DISABLED      = 3'd7
   } state_type;

   typedef enum logic [3:0] {
      EV_INIT       = 4'd0,
      EV_ENABLE     = 4'd1,
      EV_DISABLE    = 4'd2,
      EV_ACTIVATE   = 4'd3,
      EV_DEACTIVATE = 4'd4,
      EV_ADDED      = 4'd5,
      EV_REMOVED    = 4'd6,
      EV_ACTIVE     = 4'd7,
      EV_TIMEOUT    = 4'd8,
      EV_EXITED     = 4'd9,
      EV_POISON     = 4'd10,
      EV_CLEAR      = 4'd11,
      EV_UNKNOWN    = 4'd12
   } event_type;

   localparam logic [3:0] EV_LAST_CODE = 4'd11;

   typedef enum logic [2:0] {
      EXIT_STOPPED     = 3'd0,
      EXIT_UNAVAILABLE = 3'd1,
      EXIT_RECOVERABLE = 3'd2,
      EXIT_POISONED    = 3'd3,
      EXIT_OTHER       = 3'd4
   } exit_type;

   typedef struct packed {
      event_type ev;
      exit_type  kind;
      logic      fail;
   } cmd_type;

   typedef struct packed {
      logic boot_enabled;
      logic boot_poisoned;
   } boot_cfg_type;

   typedef struct packed {
      state_type  new_state;
      state_type  old_state;
      logic       transitioned;
      logic       ok;
      logic       start_req;
      logic       stop_req;
      logic       persist_write;
      logic       persist_value;
      logic       poison_record_req;
      logic       poison_clear_req;
      logic [3:0] status_flags;
   } rsp_type;

   typedef enum logic {
      CSR_BOOT_ENABLED  = 1'b0,
      CSR_BOOT_POISONED = 1'b1
   } csr_index_type;

endpackage

// ===== design/dslf_front.sv =====
// Front end: takes incoming event items and classifies them into commands.
// Depends on dslf_pkg.
module dslf_front (
   input  logic [3:0]       req_func,
   input  logic [2:0]       req_child_result,
   input  logic             req_action_fail,
   output dslf_pkg::cmd_type cmd
);

   always_comb begin
      if (req_func <= dslf_pkg::EV_LAST_CODE) begin
         cmd.ev = dslf_pkg::event_type'(req_func);
      end else begin
         cmd.ev = dslf_pkg::EV_UNKNOWN;
      end
      if (req_child_result <= 3'(dslf_pkg::EXIT_POISONED)) begin
         cmd.kind = dslf_pkg::exit_type'(req_child_result);
      end else begin
         cmd.kind = dslf_pkg::EXIT_OTHER;
      end
      cmd.fail = req_action_fail;
   end

endmodule

// ===== design/dslf_queue.sv =====
// Short command queue between the front end and the execution back end.
// Depends on dslf_pkg.
module dslf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  dslf_pkg::cmd_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output dslf_pkg::cmd_type pop_data
);

   dslf_pkg::cmd_type                      entry_ff [dslf_pkg::QUEUE_DEPTH];
   logic [dslf_pkg::QUEUE_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [dslf_pkg::QUEUE_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [dslf_pkg::QUEUE_CNT_W-1:0]       count_ff, count_in;
   logic                                   push_fire;
   logic                                   pop_fire;

   localparam logic [dslf_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      dslf_pkg::QUEUE_PTR_W'(dslf_pkg::QUEUE_DEPTH - 1);
   localparam logic [dslf_pkg::QUEUE_CNT_W-1:0] FULL_COUNT =
      dslf_pkg::QUEUE_CNT_W'(dslf_pkg::QUEUE_DEPTH);

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/dslf_back.sv =====
// Back end: holds the lifecycle state, carries out one command per cycle unless
// the result stalls, and registers the result item. Depends on dslf_pkg.
module dslf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  dslf_pkg::boot_cfg_type boot_cfg,
   input  logic                   cmd_valid,
   output logic                   cmd_ready,
   input  dslf_pkg::cmd_type      cmd,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output dslf_pkg::rsp_type      rsp
);

   dslf_pkg::state_type cur_state_ff, cur_state_in;
   dslf_pkg::state_type after_disc_ff, after_disc_in;
   logic                enable_intent_ff, enable_intent_in;
   logic                activate_intent_ff, activate_intent_in;
   logic                sink_here_ff, sink_here_in;
   logic                child_up_ff, child_up_in;
   logic                removed_poisoned_ff, removed_poisoned_in;
   logic                recovery_seen_ff, recovery_seen_in;
   logic                rsp_valid_ff, rsp_valid_in;
   dslf_pkg::rsp_type   rsp_ff, rsp_in;
   logic                fire;

   always_comb begin
      cmd_ready    = !rsp_valid_ff || rsp_ready;
      fire         = cmd_valid && cmd_ready;
      rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);
      rsp_valid    = rsp_valid_ff;
      rsp          = rsp_ff;
   end

   always_comb begin
      dslf_pkg::state_type st;
      dslf_pkg::state_type ad;
      logic en, ac, sh, cu, rwp, rs;
      logic chg, ok, start, stop, pw, pv, prec, pclr;
      logic start_try, start_fail, poison_try, poison_fail, fresh;

      st = cur_state_ff;
      ad = after_disc_ff;
      en = enable_intent_ff;
      ac = activate_intent_ff;
      sh = sink_here_ff;
      cu = child_up_ff;
      rwp = removed_poisoned_ff;
      rs = recovery_seen_ff;
      chg = 1'b0;
      ok = 1'b1;
      start = 1'b0;
      stop = 1'b0;
      pw = 1'b0;
      pv = 1'b0;
      prec = 1'b0;
      pclr = 1'b0;
      start_try = 1'b0;
      start_fail = cmd.fail;
      poison_try = 1'b0;
      poison_fail = cmd.fail;
      fresh = 1'b0;

      unique case (cmd.ev)
         dslf_pkg::EV_INIT: begin
            if (boot_cfg.boot_poisoned) begin
               st = dslf_pkg::ST_POISONED;
            end else if (boot_cfg.boot_enabled) begin
               st = dslf_pkg::ST_UNAVAIL;
            end else begin
               st = dslf_pkg::ST_DISABLED;
            end
            en = boot_cfg.boot_enabled && !boot_cfg.boot_poisoned;
            ac = 1'b0;
            sh = 1'b0;
            cu = 1'b0;
            rwp = 1'b0;
            rs = 1'b0;
            ad = dslf_pkg::ST_UNAVAIL;
            chg = (st != cur_state_ff);
         end
         dslf_pkg::EV_ENABLE: begin
            if (st == dslf_pkg::ST_POISONED) begin
               ok = 1'b0;
            end else if (!en && cmd.fail) begin
               pw = 1'b1;
               pv = 1'b1;
               ok = 1'b0;
            end else begin
               if (!en) begin
                  pw = 1'b1;
                  pv = 1'b1;
                  en = 1'b1;
                  start_fail = 1'b0;
               end
               chg = chg | (st != (sh ? dslf_pkg::ST_AVAIL : dslf_pkg::ST_UNAVAIL));
               st = sh ? dslf_pkg::ST_AVAIL : dslf_pkg::ST_UNAVAIL;
               start_try = 1'b1;
            end
         end
         dslf_pkg::EV_DISABLE: begin
            ac = 1'b0;
            if (en && cmd.fail) begin
               pw = 1'b1;
               ok = 1'b0;
            end else begin
               if (en) begin
                  pw = 1'b1;
                  en = 1'b0;
               end
               if (st != dslf_pkg::ST_POISONED) begin
                  if (cu) begin
                     ad = dslf_pkg::ST_DISABLED;
                     chg = chg | (st != dslf_pkg::ST_DISCONNECTING);
                     st = dslf_pkg::ST_DISCONNECTING;
                     stop = 1'b1;
                  end else begin
                     chg = chg | (st != dslf_pkg::ST_DISABLED);
                     st = dslf_pkg::ST_DISABLED;
                  end
               end
            end
         end
         dslf_pkg::EV_ACTIVATE: begin
            if (!en || st == dslf_pkg::ST_POISONED) begin
               ok = 1'b0;
            end else begin
               ac = 1'b1;
               if (st == dslf_pkg::ST_RECOV && sh) begin
                  chg = 1'b1;
                  st = dslf_pkg::ST_AVAIL;
               end
               start_try = 1'b1;
            end
         end
         dslf_pkg::EV_DEACTIVATE: begin
            ac = 1'b0;
            if (st == dslf_pkg::ST_POISONED) begin
               ok = 1'b0;
            end else if (cu) begin
               if (!en) begin
                  ad = dslf_pkg::ST_DISABLED;
               end else begin
                  ad = sh ? dslf_pkg::ST_AVAIL : dslf_pkg::ST_UNAVAIL;
               end
               chg = chg | (st != dslf_pkg::ST_DISCONNECTING);
               st = dslf_pkg::ST_DISCONNECTING;
               stop = 1'b1;
            end else if (st == dslf_pkg::ST_RECOV) begin
               chg = 1'b1;
               st = sh ? dslf_pkg::ST_AVAIL : dslf_pkg::ST_UNAVAIL;
            end
         end
         dslf_pkg::EV_ADDED: begin
            fresh = !sh;
            sh = 1'b1;
            if (st == dslf_pkg::ST_POISONED) begin
               if (rwp) begin
                  rs = 1'b1;
               end
            end else if (fresh && en && !cu) begin
               chg = chg | (st != dslf_pkg::ST_AVAIL);
               st = dslf_pkg::ST_AVAIL;
               start_try = 1'b1;
            end
         end
         dslf_pkg::EV_REMOVED: begin
            sh = 1'b0;
            ac = 1'b0;
            if (st == dslf_pkg::ST_POISONED) begin
               rwp = 1'b1;
               rs = 1'b0;
            end else if (cu) begin
               ad = en ? dslf_pkg::ST_UNAVAIL : dslf_pkg::ST_DISABLED;
               chg = chg | (st != dslf_pkg::ST_DISCONNECTING);
               st = dslf_pkg::ST_DISCONNECTING;
               stop = 1'b1;
            end else if (en) begin
               chg = chg | (st != dslf_pkg::ST_UNAVAIL);
               st = dslf_pkg::ST_UNAVAIL;
            end
         end
         dslf_pkg::EV_ACTIVE: begin
            if (cu && st == dslf_pkg::ST_CONNECTING) begin
               chg = 1'b1;
               st = dslf_pkg::ST_ACTIVE;
            end
         end
         dslf_pkg::EV_TIMEOUT: begin
            if (cu && st == dslf_pkg::ST_CONNECTING) begin
               chg = 1'b1;
               st = dslf_pkg::ST_RECOV;
               stop = 1'b1;
            end
         end
         dslf_pkg::EV_EXITED: begin
            cu = 1'b0;
            if (st != dslf_pkg::ST_POISONED) begin
               if (cmd.kind == dslf_pkg::EXIT_POISONED) begin
                  poison_try = 1'b1;
               end else if (st == dslf_pkg::ST_DISCONNECTING &&
                            cmd.kind == dslf_pkg::EXIT_STOPPED) begin
                  chg = 1'b1;
                  st = (en && sh) ? dslf_pkg::ST_AVAIL : ad;
                  chg = (st != dslf_pkg::ST_DISCONNECTING);
               end else if (cmd.kind == dslf_pkg::EXIT_UNAVAILABLE) begin
                  sh = 1'b0;
                  chg = chg | (st != (en ? dslf_pkg::ST_UNAVAIL : dslf_pkg::ST_DISABLED));
                  st = en ? dslf_pkg::ST_UNAVAIL : dslf_pkg::ST_DISABLED;
               end else if (cmd.kind == dslf_pkg::EXIT_RECOVERABLE || ac) begin
                  chg = chg | (st != dslf_pkg::ST_RECOV);
                  st = dslf_pkg::ST_RECOV;
               end else if (!en) begin
                  chg = chg | (st != dslf_pkg::ST_DISABLED);
                  st = dslf_pkg::ST_DISABLED;
               end else begin
                  chg = chg | (st != (sh ? dslf_pkg::ST_AVAIL : dslf_pkg::ST_UNAVAIL));
                  st = sh ? dslf_pkg::ST_AVAIL : dslf_pkg::ST_UNAVAIL;
               end
            end
         end
         dslf_pkg::EV_POISON: begin
            poison_try = 1'b1;
         end
         dslf_pkg::EV_CLEAR: begin
            if (st != dslf_pkg::ST_POISONED || !rs) begin
               ok = 1'b0;
            end else begin
               pclr = 1'b1;
               if (cmd.fail) begin
                  ok = 1'b0;
               end else begin
                  rwp = 1'b0;
                  rs = 1'b0;
                  chg = 1'b1;
                  st = dslf_pkg::ST_DISABLED;
               end
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase

      if (start_try && ac && en && sh && !cu && st != dslf_pkg::ST_POISONED) begin
         start = 1'b1;
         chg = 1'b1;
         cu = !start_fail;
         st = start_fail ? dslf_pkg::ST_RECOV : dslf_pkg::ST_CONNECTING;
      end

      if (cmd.ev == dslf_pkg::EV_ACTIVATE && ok) begin
         ok = (st != dslf_pkg::ST_RECOV);
      end

      if (poison_try && st != dslf_pkg::ST_POISONED) begin
         prec = 1'b1;
         if (!poison_fail && en) begin
            pw = 1'b1;
         end
         en = 1'b0;
         ac = 1'b0;
         chg = 1'b1;
         st = dslf_pkg::ST_POISONED;
         if (cu) begin
            stop = 1'b1;
         end
      end

      cur_state_in        = st;
      after_disc_in       = ad;
      enable_intent_in    = en;
      activate_intent_in  = ac;
      sink_here_in        = sh;
      child_up_in         = cu;
      removed_poisoned_in = rwp;
      recovery_seen_in    = rs;

      rsp_in.new_state         = st;
      rsp_in.old_state         = cur_state_ff;
      rsp_in.transitioned      = chg;
      rsp_in.ok                = ok;
      rsp_in.start_req         = start;
      rsp_in.stop_req          = stop;
      rsp_in.persist_write     = pw;
      rsp_in.persist_value     = pw && pv;
      rsp_in.poison_record_req = prec;
      rsp_in.poison_clear_req  = pclr;
      rsp_in.status_flags      = {rs, sh, ac, en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_state_ff        <= dslf_pkg::ST_UNAVAIL;
         after_disc_ff       <= dslf_pkg::ST_UNAVAIL;
         enable_intent_ff    <= 1'b1;
         activate_intent_ff  <= 1'b0;
         sink_here_ff        <= 1'b0;
         child_up_ff         <= 1'b0;
         removed_poisoned_ff <= 1'b0;
         recovery_seen_ff    <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            cur_state_ff        <= cur_state_in;
            after_disc_ff       <= after_disc_in;
            enable_intent_ff    <= enable_intent_in;
            activate_intent_ff  <= activate_intent_in;
            sink_here_ff        <= sink_here_in;
            child_up_ff         <= child_up_in;
            removed_poisoned_ff <= removed_poisoned_in;
            recovery_seen_ff    <= recovery_seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== design/display_sink_lifecycle_fsm.sv =====
// Connection lifecycle controller for a hot-pluggable display sink. Each
// event item produces exactly one result item, registered in the back end. One
// event is executed per cycle when the result side keeps up, and a two-entry
// command queue lets the input side run ahead of a stalled result. Depends on
// dslf_pkg, dslf_front, dslf_queue, dslf_back.
module display_sink_lifecycle_fsm (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // Fields from bit 0: func[3:0], child_result[2:0], action_fail.
   input  logic [dslf_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // Fields from bit 0: new_state[2:0], old_state[2:0], transitioned, ok,
   // start_req, stop_req, persist_write, persist_value, poison_record_req,
   // poison_clear_req, status_flags[3:0], then zero padding.
   output logic [dslf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic                           csr_wdata
);

   dslf_pkg::boot_cfg_type boot_cfg_ff, boot_cfg_in;
   dslf_pkg::cmd_type      front_cmd;
   dslf_pkg::cmd_type      queue_cmd;
   logic                   queue_valid;
   logic                   queue_ready;
   dslf_pkg::rsp_type      rsp;

   always_comb begin
      boot_cfg_in = boot_cfg_ff;
      if (csr_we) begin
         unique case (dslf_pkg::csr_index_type'(csr_index))
            dslf_pkg::CSR_BOOT_ENABLED:  boot_cfg_in.boot_enabled  = csr_wdata;
            dslf_pkg::CSR_BOOT_POISONED: boot_cfg_in.boot_poisoned = csr_wdata;
            default: boot_cfg_in = boot_cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         boot_cfg_ff.boot_enabled  <= 1'b1;
         boot_cfg_ff.boot_poisoned <= 1'b0;
      end else begin
         boot_cfg_ff <= boot_cfg_in;
      end
   end

   dslf_front u_front (
      .req_func         (req_tdata[3:0]),
      .req_child_result (req_tdata[6:4]),
      .req_action_fail  (req_tdata[7]),
      .cmd              (front_cmd)
   );

   dslf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_data  (front_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_cmd)
   );

   dslf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .boot_cfg  (boot_cfg_ff),
      .cmd_valid (queue_valid),
      .cmd_ready (queue_ready),
      .cmd       (queue_cmd),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {6'b0, rsp.status_flags, rsp.poison_clear_req,
                       rsp.poison_record_req, rsp.persist_value, rsp.persist_write,
                       rsp.stop_req, rsp.start_req, rsp.ok, rsp.transitioned,
                       rsp.old_state, rsp.new_state};

endmodule
